// ===== rtl/seg_int_pkg.sv =====
// ----------------------------------------------------------------------------
// seg_int_pkg: shared definitions for the segment intersection test
// Holds the default coordinate width and the orientation sign type.
// ----------------------------------------------------------------------------
package seg_int_pkg;

	// Default width of one signed coordinate.
	localparam int COORD_BITS_DEF = 16;

	// Number of orientation tests per segment pair.
	localparam int N_ORIENT = 4;

	// Sign of one cross product: pos means left turn, neg right turn,
	// both clear means collinear.
	typedef struct packed {
		logic pos;
		logic neg;
	} orient_t;

endpackage

// ===== rtl/segment_intersection_test.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_test: pipelined test whether two segments meet
// Four orientation cross products plus bounding-box checks, one pair a cycle while the pipeline can advance.
// ----------------------------------------------------------------------------
// Usage:
// A segment pair arrives on the slave stream (s_tvalid, s_tready, s_tdata)
// and its verdict leaves on the master stream (m_tvalid, m_tready, m_tdata).
// Each input transfer produces exactly one output transfer, in order.
// An input transfer passes the stage 1, 2, 3 and 4 registers before m_tvalid
// rises. Throughput is one pair per cycle: a new pair is taken in every cycle
// while the pipeline can advance.
// The four stages are: coordinate differences and bounding-box compares,
// the eight full-width multiplications, the product compares that give each
// orientation sign, and the final decision in the output register.
// The whole pipeline moves on one enable. When the receiver holds m_tready
// low while a result is waiting, every stage freezes and s_tready drops, so
// nothing is lost or repeated; empty stages still fill while the output
// register is empty.
// Reset clears all valid bits, so the block comes up empty and ready.
// There are no configuration registers and no state between pairs.
// ----------------------------------------------------------------------------
module segment_intersection_test #(
	parameter int COORD_BITS = seg_int_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// s_tdata, from the lowest bit up: first_start_x, first_start_y,
	// first_end_x, first_end_y, second_start_x, second_start_y,
	// second_end_x, second_end_y, each COORD_BITS wide, signed.
	input  logic [8*COORD_BITS-1:0] s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// m_tdata, from the lowest bit up: segments_meet, then seven zero bits.
	output logic [7:0]              m_tdata
);
	import seg_int_pkg::*;

	// Differences need one bit more than a coordinate, products twice that.
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	// The single enable: advance whenever the output register is free or
	// is being emptied in this cycle.
	logic en;
	assign en       = m_tready || !m_tvalid;
	assign s_tready = en;

	// Unpack the eight coordinates.
	logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, dx, dy;
	assign ax = s_tdata[0*COORD_BITS +: COORD_BITS];
	assign ay = s_tdata[1*COORD_BITS +: COORD_BITS];
	assign bx = s_tdata[2*COORD_BITS +: COORD_BITS];
	assign by = s_tdata[3*COORD_BITS +: COORD_BITS];
	assign cx = s_tdata[4*COORD_BITS +: COORD_BITS];
	assign cy = s_tdata[5*COORD_BITS +: COORD_BITS];
	assign dx = s_tdata[6*COORD_BITS +: COORD_BITS];
	assign dy = s_tdata[7*COORD_BITS +: COORD_BITS];

	// Test r lies within the box spanned by p and q, ends included.
	function automatic logic between(logic signed [COORD_BITS-1:0] p,
	                                 logic signed [COORD_BITS-1:0] q,
	                                 logic signed [COORD_BITS-1:0] r);
		logic signed [COORD_BITS-1:0] lo;
		logic signed [COORD_BITS-1:0] hi;
		lo = (p < q) ? p : q;
		hi = (p < q) ? q : p;
		return (lo <= r) && (r <= hi);
	endfunction

	// ---------------- Stage 1: differences and box tests ----------------
	// Orientation k uses segment P->Q and point R:
	//   0: a->b with c, 1: a->b with d, 2: c->d with a, 3: c->d with b.
	// Its cross product is dx1*dy2 - dy1*dx2.
	logic                 valid_s1;
	logic signed [DW-1:0] dx1_s1 [N_ORIENT];
	logic signed [DW-1:0] dy1_s1 [N_ORIENT];
	logic signed [DW-1:0] dx2_s1 [N_ORIENT];
	logic signed [DW-1:0] dy2_s1 [N_ORIENT];
	logic [N_ORIENT-1:0]  box_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx1_s1[0] <= DW'(bx) - DW'(ax);
			dy1_s1[0] <= DW'(by) - DW'(ay);
			dx2_s1[0] <= DW'(cx) - DW'(ax);
			dy2_s1[0] <= DW'(cy) - DW'(ay);

			dx1_s1[1] <= DW'(bx) - DW'(ax);
			dy1_s1[1] <= DW'(by) - DW'(ay);
			dx2_s1[1] <= DW'(dx) - DW'(ax);
			dy2_s1[1] <= DW'(dy) - DW'(ay);

			dx1_s1[2] <= DW'(dx) - DW'(cx);
			dy1_s1[2] <= DW'(dy) - DW'(cy);
			dx2_s1[2] <= DW'(ax) - DW'(cx);
			dy2_s1[2] <= DW'(ay) - DW'(cy);

			dx1_s1[3] <= DW'(dx) - DW'(cx);
			dy1_s1[3] <= DW'(dy) - DW'(cy);
			dx2_s1[3] <= DW'(bx) - DW'(cx);
			dy2_s1[3] <= DW'(by) - DW'(cy);

			box_s1[0] <= between(ax, bx, cx) && between(ay, by, cy);
			box_s1[1] <= between(ax, bx, dx) && between(ay, by, dy);
			box_s1[2] <= between(cx, dx, ax) && between(cy, dy, ay);
			box_s1[3] <= between(cx, dx, bx) && between(cy, dy, by);
		end
	end

	// ---------------- Stage 2: full-width products ----------------
	logic                 valid_s2;
	logic signed [PW-1:0] lprod_s2 [N_ORIENT];
	logic signed [PW-1:0] rprod_s2 [N_ORIENT];
	logic [N_ORIENT-1:0]  box_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_ORIENT; k++) begin
				lprod_s2[k] <= PW'(dx1_s1[k]) * PW'(dy2_s1[k]);
				rprod_s2[k] <= PW'(dy1_s1[k]) * PW'(dx2_s1[k]);
			end
			box_s2 <= box_s1;
		end
	end

	// ---------------- Stage 3: orientation signs ----------------
	logic                valid_s3;
	orient_t             orient_s3 [N_ORIENT];
	logic [N_ORIENT-1:0] box_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_ORIENT; k++) begin
				orient_s3[k].pos <= lprod_s2[k] > rprod_s2[k];
				orient_s3[k].neg <= lprod_s2[k] < rprod_s2[k];
			end
			box_s3 <= box_s2;
		end
	end

	// ---------------- Stage 4: decision and output register ----------------
	// A proper crossing needs both orientation pairs nonzero and of opposite
	// sign. Otherwise a collinear endpoint inside the other segment's box
	// counts as touching or overlap.
	logic cross_c;
	logic touch_c;
	logic meet_s4;
	logic valid_s4;

	always_comb begin
		cross_c = (orient_s3[0].pos && orient_s3[1].neg ||
		           orient_s3[0].neg && orient_s3[1].pos) &&
		          (orient_s3[2].pos && orient_s3[3].neg ||
		           orient_s3[2].neg && orient_s3[3].pos);
		touch_c = 1'b0;
		for (int k = 0; k < N_ORIENT; k++) begin
			if (!orient_s3[k].pos && !orient_s3[k].neg && box_s3[k]) begin
				touch_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meet_s4 <= cross_c || touch_c;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {7'b0, meet_s4};

	// ---------------- Assertions ----------------
	// A compare never reports both a left and a right turn.
	a_orient_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> !(orient_s3[0].pos && orient_s3[0].neg) &&
		             !(orient_s3[1].pos && orient_s3[1].neg) &&
		             !(orient_s3[2].pos && orient_s3[2].neg) &&
		             !(orient_s3[3].pos && orient_s3[3].neg))
		else $error("orientation both positive and negative");

	// A proper crossing always yields a meet on the output.
	a_cross_meets: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && en && cross_c |=> m_tvalid && m_tdata[0])
		else $error("proper crossing not reported");

	// Stage two, when valid while the pipeline advances, hands its item on to stage three.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && en |=> valid_s3)
		else $error("item dropped between stages two and three");

	// While stalled the held result keeps its verdict.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> m_tvalid && $stable(meet_s4))
		else $error("stalled result changed");

endmodule
